FILE: sv/msb_pkg.sv
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and register codes for the masked saturation balance block.
// ----------------------------------------------------------------------------
package msb_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_MASK_THRESHOLD   = 3'd0;
   localparam logic [2:0] CSR_SATURATION_SCALE = 3'd1;
   localparam logic [2:0] CSR_OFFSET_RED       = 3'd2;
   localparam logic [2:0] CSR_OFFSET_GREEN     = 3'd3;
   localparam logic [2:0] CSR_OFFSET_BLUE      = 3'd4;
   localparam logic [2:0] CSR_IMAGE_WIDTH      = 3'd5;
   localparam logic [2:0] CSR_IMAGE_HEIGHT     = 3'd6;

   // widest register and its reset values
   localparam int CSR_DW = 13;
   localparam logic [7:0]  RST_MASK_THRESHOLD   = 8'd77;
   localparam logic [11:0] RST_SATURATION_SCALE = 12'd256;
   localparam logic [8:0]  RST_OFFSET           = 9'd0;
   localparam logic [11:0] RST_IMAGE_WIDTH      = 12'd640;
   localparam logic [12:0] RST_IMAGE_HEIGHT     = 13'd480;

   // smallest frame edge the row logic accepts
   localparam logic [12:0] MIN_HEIGHT = 13'd3;

   // input beat
   typedef struct packed {
      logic [7:0] pix_r;
      logic [7:0] pix_g;
      logic [7:0] pix_b;
      logic [7:0] mask_value;
      logic       pad_item;
   } req_type;

   // result beat
   typedef struct packed {
      logic [7:0] out_r;
      logic [7:0] out_g;
      logic [7:0] out_b;
      logic       out_frame_end;
   } rsp_type;

   // line store access control
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic bank;
   } lsc_type;

endpackage

FILE: sv/msb_line_store.sv
// ----------------------------------------------------------------------------
// msb_line_store
// Two banks of mask line storage and one pixel line, read before write.
// ----------------------------------------------------------------------------
module msb_line_store
   import msb_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  lsc_type                      lsc,
   input  logic [$clog2(MAX_WIDTH)-1:0] col,
   input  logic [$clog2(MAX_WIDTH)-1:0] col_next,
   input  logic [7:0]                   wr_mask,
   input  logic [23:0]                  wr_pix,
   output logic [7:0]                   rd_up,
   output logic [7:0]                   rd_mid,
   output logic [7:0]                   rd_right,
   output logic [23:0]                  rd_pix
);

   logic [7:0]  bank0_mem [MAX_WIDTH];
   logic [7:0]  bank1_mem [MAX_WIDTH];
   logic [23:0] pix_mem   [MAX_WIDTH];

   logic [7:0]  b0_q0_ff, b0_q1_ff, b1_q0_ff, b1_q1_ff;
   logic [23:0] pix_q_ff;
   logic        bank_ff;

   // bank 0: current row writes, previous row reads at column and column+1
   always_ff @(posedge clock) begin
      if (lsc.rd_en) begin
         if (lsc.wr_en && !lsc.bank) begin
            bank0_mem[col] <= wr_mask;
         end
         b0_q0_ff <= bank0_mem[col];
         b0_q1_ff <= bank0_mem[col_next];
      end
   end

   // bank 1
   always_ff @(posedge clock) begin
      if (lsc.rd_en) begin
         if (lsc.wr_en && lsc.bank) begin
            bank1_mem[col] <= wr_mask;
         end
         b1_q0_ff <= bank1_mem[col];
         b1_q1_ff <= bank1_mem[col_next];
      end
   end

   // pixel line, old row out and new row in at the same column
   always_ff @(posedge clock) begin
      if (lsc.rd_en) begin
         if (lsc.wr_en) begin
            pix_mem[col] <= wr_pix;
         end
         pix_q_ff <= pix_mem[col];
         bank_ff  <= lsc.bank;
      end
   end

   // bank named by the row parity holds the row above, the other the centre row
   assign rd_up    = bank_ff ? b1_q0_ff : b0_q0_ff;
   assign rd_mid   = bank_ff ? b0_q0_ff : b1_q0_ff;
   assign rd_right = bank_ff ? b0_q1_ff : b1_q1_ff;
   assign rd_pix   = pix_q_ff;

endmodule

FILE: sv/msb_chan.sv
// ----------------------------------------------------------------------------
// msb_chan
// One colour channel: chroma gain multiply, then offset, rounding and clamp.
// ----------------------------------------------------------------------------
module msb_chan
   import msb_pkg::*;
(
   input  logic        clock,
   input  logic        en_mul,
   input  logic        en_out,
   input  logic [7:0]  c_in,
   input  logic [7:0]  luma,
   input  logic [8:0]  offset,
   input  logic [11:0] scale,
   input  logic        full,
   input  logic        adj,
   output logic [7:0]  res
);

   logic signed [8:0]  diff;
   logic        [12:0] gain;
   logic signed [10:0] off_ext;
   logic signed [10:0] lsum;
   logic signed [22:0] prod_in;
   logic signed [19:0] base_in;

   logic signed [22:0] prod_ff;
   logic signed [19:0] base_ff;
   logic               full_ff;
   logic               adj_ff;
   logic        [7:0]  c_ff;

   logic signed [22:0] sum;
   logic signed [22:0] shifted;
   logic        [7:0]  sat;
   logic        [7:0]  res_in;
   logic        [7:0]  res_ff;

   // half strength uses scale+256 over 512, full strength scale over 256
   always_comb begin
      diff    = $signed({1'b0, c_in}) - $signed({1'b0, luma});
      gain    = full ? {1'b0, scale} : {1'b0, scale} + 13'd256;
      off_ext = {{2{offset[8]}}, offset};
      lsum    = full ? $signed({3'b000, luma}) + off_ext
                     : $signed({2'b00, luma, 1'b0}) + off_ext;
      prod_in = 23'(diff) * 23'($signed({1'b0, gain}));
      base_in = 20'($signed({lsum, 8'd0})) + (full ? 20'sd128 : 20'sd256);
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (en_mul) begin
         prod_ff <= prod_in;
         base_ff <= base_in;
         full_ff <= full;
         adj_ff  <= adj;
         c_ff    <= c_in;
      end
   end

   // floor shift and clamp to 0..255
   always_comb begin
      sum     = prod_ff + 23'(base_ff);
      shifted = full_ff ? (sum >>> 8) : (sum >>> 9);
      if (shifted < 23'sd0) begin
         sat = 8'd0;
      end else if (shifted > 23'sd255) begin
         sat = 8'd255;
      end else begin
         sat = shifted[7:0];
      end
      res_in = adj_ff ? sat : c_ff;
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

FILE: sv/masked_saturation_balance.sv
// ----------------------------------------------------------------------------
// masked_saturation_balance
// Mask-driven luma-based saturation and colour balance over a pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock and gives one result beat per clock, unless
// rsp_stall holds them, once the first row has gone in; results for a row
// come out while the next row is fed, so a frame of height rows needs width
// pad beats after it to flush the last row. Each beat is registered in turn
// by the line store read, threshold and luma, the gain multiply, and round
// and clamp. The line store holds two mask rows and one pixel row of
// MAX_WIDTH entries; the mask rows are read at the column and the next column
// in the same cycle. It starts uninitialised and needs no clearing pass.
// Pad beats inside pixel rows are taken and dropped. The user must write
// registers only while the pipeline is empty; the block does not enforce it.
module masked_saturation_balance
   import msb_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > 12) ? WW : 12;

   // configuration registers
   logic [7:0]  thr_ff;
   logic [11:0] scale_ff;
   logic [8:0]  off_r_ff, off_g_ff, off_b_ff;
   logic [11:0] width_ff;
   logic [12:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= RST_MASK_THRESHOLD;
         scale_ff  <= RST_SATURATION_SCALE;
         off_r_ff  <= RST_OFFSET;
         off_g_ff  <= RST_OFFSET;
         off_b_ff  <= RST_OFFSET;
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MASK_THRESHOLD:   thr_ff    <= csr_wdata[7:0];
            CSR_SATURATION_SCALE: scale_ff  <= csr_wdata[11:0];
            CSR_OFFSET_RED:       off_r_ff  <= csr_wdata[8:0];
            CSR_OFFSET_GREEN:     off_g_ff  <= csr_wdata[8:0];
            CSR_OFFSET_BLUE:      off_b_ff  <= csr_wdata[8:0];
            CSR_IMAGE_WIDTH:      width_ff  <= csr_wdata[11:0];
            CSR_IMAGE_HEIGHT:     height_ff <= csr_wdata[12:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline enables, a stage loads when empty or when it moves on
   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic en1, en2, en3, en4;
   logic req_acc;

   assign en4       = !out_v_ff || !rsp_stall;
   assign en3       = !s3_v_ff || en4;
   assign en2       = !s2_v_ff || en3;
   assign en1       = !s1_v_ff || en2;
   assign req_stall = !en1;
   assign req_acc   = req_valid && en1;

   // frame position
   logic [AW-1:0] col_ff;
   logic [12:0]   row_ff;
   logic [CW-1:0] w_ext, w_cmp;
   logic [WW-1:0] w_eff;
   logic [12:0]   h_eff;
   logic [AW-1:0] col_eff, col_next;
   logic [12:0]   row_eff;
   logic          flush, last, process, has_out, interior, fend;

   always_comb begin
      w_ext = CW'(width_ff);
      if (w_ext < CW'(3)) begin
         w_cmp = CW'(3);
      end else if (w_ext > CW'(MAX_WIDTH)) begin
         w_cmp = CW'(MAX_WIDTH);
      end else begin
         w_cmp = w_ext;
      end
      w_eff    = WW'(w_cmp);
      h_eff    = (height_ff < MIN_HEIGHT) ? MIN_HEIGHT : height_ff;
      col_eff  = (WW'(col_ff) >= w_eff) ? '0 : col_ff;
      col_next = (WW'(col_eff) == WW'(MAX_WIDTH - 1)) ? '0 : col_eff + AW'(1);
      last     = (WW'(col_eff) + WW'(1)) >= w_eff;
      flush    = row_ff >= h_eff;
      row_eff  = flush ? h_eff : row_ff;
      process  = !(req_data.pad_item && !flush);
      has_out  = process && (row_eff != 13'd0);
      interior = (row_eff >= 13'd2) && !flush && (col_eff != '0) && !last;
      fend     = flush && last;
   end

   // column and row counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         if (!process) begin
            col_ff <= col_eff;
         end else if (last) begin
            col_ff <= '0;
            row_ff <= flush ? 13'd0 : row_eff + 13'd1;
         end else begin
            col_ff <= col_eff + AW'(1);
         end
      end
   end

   // line store, read stage
   lsc_type     lsc;
   logic [7:0]  ls_up, ls_mid, ls_right;
   logic [23:0] ls_pix;

   assign lsc.rd_en = req_acc;
   assign lsc.wr_en = process && !flush;
   assign lsc.bank  = row_eff[0];

   msb_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock    (clock),
      .lsc      (lsc),
      .col      (col_eff),
      .col_next (col_next),
      .wr_mask  (req_data.mask_value),
      .wr_pix   ({req_data.pix_r, req_data.pix_g, req_data.pix_b}),
      .rd_up    (ls_up),
      .rd_mid   (ls_mid),
      .rd_right (ls_right),
      .rd_pix   (ls_pix)
   );

   logic       s1_interior_ff, s1_fend_ff;
   logic [7:0] s1_down_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en1) begin
         s1_v_ff <= req_acc && has_out;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_interior_ff <= interior;
         s1_fend_ff     <= fend;
         s1_down_ff     <= req_data.mask_value;
      end
   end

   // threshold tests and luma
   logic [7:0]  left_ff;
   logic        full, half, near;
   logic [10:0] luma_sum;
   logic [7:0]  pr, pg, pb;

   always_comb begin
      pr       = ls_pix[23:16];
      pg       = ls_pix[15:8];
      pb       = ls_pix[7:0];
      full     = ls_mid >= thr_ff;
      near     = (left_ff >= thr_ff) || (ls_right >= thr_ff) ||
                 (ls_up >= thr_ff) || (s1_down_ff >= thr_ff);
      half     = !full && s1_interior_ff && near;
      luma_sum = 11'({pr, 1'b0}) + 11'(pr) + 11'({pg, 2'b00}) + 11'(pb) + 11'd4;
   end

   // centre mask of the beat ahead is the left neighbour of the next one
   always_ff @(posedge clock) begin
      if (en2 && s1_v_ff) begin
         left_ff <= ls_mid;
      end
   end

   logic [7:0] s2_r_ff, s2_g_ff, s2_b_ff, s2_luma_ff;
   logic       s2_full_ff, s2_adj_ff, s2_fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_r_ff    <= pr;
         s2_g_ff    <= pg;
         s2_b_ff    <= pb;
         s2_luma_ff <= luma_sum[10:3];
         s2_full_ff <= full;
         s2_adj_ff  <= full || half;
         s2_fend_ff <= s1_fend_ff;
      end
   end

   // per-channel multiply and clamp stages
   logic [7:0] res_r, res_g, res_b;

   msb_chan u_chan_r (
      .clock  (clock),
      .en_mul (en3),
      .en_out (en4),
      .c_in   (s2_r_ff),
      .luma   (s2_luma_ff),
      .offset (off_r_ff),
      .scale  (scale_ff),
      .full   (s2_full_ff),
      .adj    (s2_adj_ff),
      .res    (res_r)
   );

   msb_chan u_chan_g (
      .clock  (clock),
      .en_mul (en3),
      .en_out (en4),
      .c_in   (s2_g_ff),
      .luma   (s2_luma_ff),
      .offset (off_g_ff),
      .scale  (scale_ff),
      .full   (s2_full_ff),
      .adj    (s2_adj_ff),
      .res    (res_g)
   );

   msb_chan u_chan_b (
      .clock  (clock),
      .en_mul (en3),
      .en_out (en4),
      .c_in   (s2_b_ff),
      .luma   (s2_luma_ff),
      .offset (off_b_ff),
      .scale  (scale_ff),
      .full   (s2_full_ff),
      .adj    (s2_adj_ff),
      .res    (res_b)
   );

   // valid and frame end travel beside the channel stages
   logic s3_fend_ff, out_fend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (en4) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_fend_ff <= s2_fend_ff;
      end
      if (en4) begin
         out_fend_ff <= s3_fend_ff;
      end
   end

   assign rsp_valid              = out_v_ff;
   assign rsp_data.out_r         = res_r;
   assign rsp_data.out_g         = res_g;
   assign rsp_data.out_b         = res_b;
   assign rsp_data.out_frame_end = out_fend_ff;

   // an empty output stage never holds back the input
   a_no_stall_when_drained : assert property (
      @(posedge clock) disable iff (reset)
      !out_v_ff |-> !req_stall
   ) else $error("input stalled with empty output stage");

   // a dropped pad beat leaves the row where it was
   a_pad_keeps_row : assert property (
      @(posedge clock) disable iff (reset)
      (req_acc && req_data.pad_item && !flush) |=> (row_ff == $past(row_ff))
   ) else $error("pad beat moved the row counter");

   // the last pixel of a pixel row steps to the next row
   a_row_step : assert property (
      @(posedge clock) disable iff (reset)
      (req_acc && process && last && !flush) |=> (row_ff == $past(row_eff) + 13'd1)
   ) else $error("row counter did not advance at end of row");

endmodule
